[hdl/npc_pkg.sv]
package npc_pkg;

	localparam int ROM_ENTRIES = 64;
	localparam int PALETTE_SIZE_DEF = 64;
	localparam int CHAN_W = 8;
	localparam int SQ_W = 2 * CHAN_W;
	localparam int DIST_W = 18;
	localparam int IDX_W = 7;

	// worst case 3 * 255 * 255
	localparam logic [DIST_W-1:0] MAX_DIST = DIST_W'(195075);
	// seed for the first cell: above any real distance
	localparam logic [DIST_W-1:0] DIST_SEED = '1;

	typedef struct packed {
		logic              valid;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [IDX_W-1:0]  best_idx;
		logic [DIST_W-1:0] best_dist;
	} link_t;

	// {red, green, blue}, entry 0 is palette index 1
	localparam logic [3*CHAN_W-1:0] PALETTE_ROM [ROM_ENTRIES] = '{
		{8'd26,  8'd10,  8'd148}, {8'd15,  8'd117, 8'd255}, {8'd0,   8'd147, 8'd76 },
		{8'd186, 8'd189, 8'd254}, {8'd236, 8'd0,   8'd0  }, {8'd228, 8'd153, 8'd90 },
		{8'd204, 8'd72,  8'd171}, {8'd253, 8'd196, 8'd250}, {8'd221, 8'd132, 8'd205},
		{8'd107, 8'd211, 8'd138}, {8'd228, 8'd169, 8'd69 }, {8'd255, 8'd189, 8'd66 },
		{8'd255, 8'd230, 8'd0  }, {8'd108, 8'd217, 8'd0  }, {8'd193, 8'd169, 8'd65 },
		{8'd181, 8'd173, 8'd151}, {8'd186, 8'd156, 8'd95 }, {8'd250, 8'd245, 8'd158},
		{8'd128, 8'd128, 8'd128}, {8'd0,   8'd0,   8'd0  }, {8'd0,   8'd28,  8'd223},
		{8'd223, 8'd0,   8'd184}, {8'd98,  8'd98,  8'd98 }, {8'd105, 8'd38,  8'd13 },
		{8'd255, 8'd0,   8'd96 }, {8'd191, 8'd130, 8'd0  }, {8'd243, 8'd145, 8'd120},
		{8'd255, 8'd104, 8'd5  }, {8'd240, 8'd240, 8'd240}, {8'd200, 8'd50,  8'd205},
		{8'd176, 8'd191, 8'd155}, {8'd101, 8'd191, 8'd235}, {8'd255, 8'd186, 8'd4  },
		{8'd255, 8'd240, 8'd108}, {8'd254, 8'd202, 8'd21 }, {8'd243, 8'd129, 8'd1  },
		{8'd55,  8'd169, 8'd35 }, {8'd35,  8'd70,  8'd95 }, {8'd166, 8'd166, 8'd149},
		{8'd206, 8'd191, 8'd166}, {8'd150, 8'd170, 8'd2  }, {8'd255, 8'd227, 8'd198},
		{8'd255, 8'd153, 8'd215}, {8'd0,   8'd112, 8'd4  }, {8'd237, 8'd204, 8'd251},
		{8'd192, 8'd137, 8'd216}, {8'd231, 8'd217, 8'd180}, {8'd233, 8'd14,  8'd134},
		{8'd207, 8'd104, 8'd41 }, {8'd64,  8'd134, 8'd21 }, {8'd219, 8'd23,  8'd151},
		{8'd255, 8'd167, 8'd4  }, {8'd185, 8'd255, 8'd255}, {8'd34,  8'd137, 8'd39 },
		{8'd182, 8'd18,  8'd205}, {8'd0,   8'd170, 8'd0  }, {8'd254, 8'd169, 8'd220},
		{8'd254, 8'd213, 8'd16 }, {8'd0,   8'd151, 8'd223}, {8'd255, 8'd255, 8'd132},
		{8'd207, 8'd231, 8'd116}, {8'd255, 8'd200, 8'd100}, {8'd255, 8'd200, 8'd200},
		{8'd255, 8'd200, 8'd200}
	};

endpackage

[hdl/npc_cell.sv]
module npc_cell #(
	parameter int INDEX = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  npc_pkg::link_t link_in,
	output npc_pkg::link_t link_out
);
	import npc_pkg::*;

	localparam logic [3*CHAN_W-1:0] COLOR = PALETTE_ROM[INDEX];
	localparam logic [CHAN_W-1:0] C_RED   = COLOR[3*CHAN_W-1:2*CHAN_W];
	localparam logic [CHAN_W-1:0] C_GREEN = COLOR[2*CHAN_W-1:CHAN_W];
	localparam logic [CHAN_W-1:0] C_BLUE  = COLOR[CHAN_W-1:0];
	localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(INDEX + 1);

	logic [CHAN_W-1:0] d_red, d_green, d_blue;
	logic              valid_s1;
	logic [CHAN_W-1:0] red_s1, green_s1, blue_s1;
	logic [IDX_W-1:0]  best_idx_s1;
	logic [DIST_W-1:0] best_dist_s1;
	logic [SQ_W-1:0]   sq_red_s1, sq_green_s1, sq_blue_s1;
	logic [DIST_W-1:0] sum_dist;
	logic              valid_s2;
	logic [CHAN_W-1:0] red_s2, green_s2, blue_s2;
	logic [IDX_W-1:0]  best_idx_s2;
	logic [DIST_W-1:0] best_dist_s2;

	assign d_red   = (link_in.red   >= C_RED)   ? link_in.red   - C_RED   : C_RED   - link_in.red;
	assign d_green = (link_in.green >= C_GREEN) ? link_in.green - C_GREEN : C_GREEN - link_in.green;
	assign d_blue  = (link_in.blue  >= C_BLUE)  ? link_in.blue  - C_BLUE  : C_BLUE  - link_in.blue;

	// stage 1: channel squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= link_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_s1       <= link_in.red;
			green_s1     <= link_in.green;
			blue_s1      <= link_in.blue;
			best_idx_s1  <= link_in.best_idx;
			best_dist_s1 <= link_in.best_dist;
			sq_red_s1    <= SQ_W'(d_red) * SQ_W'(d_red);
			sq_green_s1  <= SQ_W'(d_green) * SQ_W'(d_green);
			sq_blue_s1   <= SQ_W'(d_blue) * SQ_W'(d_blue);
		end
	end

	// stage 2: sum and strict compare, earlier entry keeps ties
	assign sum_dist = DIST_W'(sq_red_s1) + DIST_W'(sq_green_s1) + DIST_W'(sq_blue_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_s2   <= red_s1;
			green_s2 <= green_s1;
			blue_s2  <= blue_s1;
			if (sum_dist < best_dist_s1) begin
				best_idx_s2  <= MY_IDX;
				best_dist_s2 <= sum_dist;
			end else begin
				best_idx_s2  <= best_idx_s1;
				best_dist_s2 <= best_dist_s1;
			end
		end
	end

	assign link_out = '{
		valid:     valid_s2,
		red:       red_s2,
		green:     green_s2,
		blue:      blue_s2,
		best_idx:  best_idx_s2,
		best_dist: best_dist_s2
	};

endmodule

[hdl/nearest_palette_color.sv]
// Path: an accepted pixel passes both registers of each cell, then the output register.
// Throughput: one pixel per cycle while not stalled; each palette cell is a two-stage
// slice (square, then sum and compare) and the whole row advances together.
// Stalls: the row freezes only while a result sits in the output register under out_stall.
// Reset: arst_n asynchronously clears all valid flags; data registers are not reset.
module nearest_palette_color #(
	parameter int PALETTE_SIZE = npc_pkg::PALETTE_SIZE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// pixel channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [npc_pkg::CHAN_W-1:0]   red,
	input  logic [npc_pkg::CHAN_W-1:0]   green,
	input  logic [npc_pkg::CHAN_W-1:0]   blue,
	// result channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [npc_pkg::IDX_W-1:0]    nearest_idx
);
	import npc_pkg::*;

	// searched entries, limited to what the ROM holds
	localparam int ROW_LEN = (PALETTE_SIZE > ROM_ENTRIES) ? ROM_ENTRIES :
		((PALETTE_SIZE < 1) ? 1 : PALETTE_SIZE);

	// Row of cells: link[k] feeds cell k (palette entry k+1), link[ROW_LEN] is the tail.
	link_t            link [ROW_LEN+1];
	logic             en;
	logic             out_valid_q;
	logic [IDX_W-1:0] nearest_idx_q;

	// The row moves unless a finished result is blocked in the output register.
	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;

	// Head of the row: the best distance is seeded above any real distance so entry 1
	// always wins its compare.
	assign link[0] = '{
		valid:     in_valid,
		red:       red,
		green:     green,
		blue:      blue,
		best_idx:  '0,
		best_dist: DIST_SEED
	};

	for (genvar k = 0; k < ROW_LEN; k++) begin : g_cell
		npc_cell #(
			.INDEX(k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.link_in (link[k]),
			.link_out(link[k+1])
		);
	end

	// Output register: holds a result while the consumer stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= link[ROW_LEN].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nearest_idx_q <= link[ROW_LEN].best_idx;
		end
	end

	assign out_valid   = out_valid_q;
	assign nearest_idx = nearest_idx_q;

	// A delivered index is always a real palette entry.
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (nearest_idx != '0) && (nearest_idx <= IDX_W'(ROW_LEN)))
		else $error("nearest_idx out of range");

	// A pixel leaving the row has been replaced by a real distance.
	a_tail_dist: assert property (@(posedge clk) disable iff (!arst_n)
		link[ROW_LEN].valid |-> link[ROW_LEN].best_dist <= MAX_DIST)
		else $error("tail distance never updated");

	// While the output is blocked the row must not move.
	a_row_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		$stable(link[ROW_LEN].valid) && $stable(link[ROW_LEN].best_idx))
		else $error("row advanced under stall");

	// A pixel leaving the row while it moves lands in the output register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(link[ROW_LEN].valid && en) |=> out_valid)
		else $error("result lost at output register");

endmodule

[dv/nearest_palette_color_checker.sv]
module nearest_palette_color_checker #(
	parameter int PALETTE_SIZE = npc_pkg::PALETTE_SIZE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [npc_pkg::CHAN_W-1:0]   red,
	input  logic [npc_pkg::CHAN_W-1:0]   green,
	input  logic [npc_pkg::CHAN_W-1:0]   blue,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [npc_pkg::IDX_W-1:0]    nearest_idx,
	output int                           mismatches,
	output int                           awaited,
	output int                           matched,
	output int                           indices_hit,
	output int                           input_backpressure
);
	timeunit 1ns;
	timeprecision 1ps;

	import npc_pkg::*;

	logic [IDX_W-1:0] expected_index_q [$];
	bit               index_seen [ROM_ENTRIES+1];

	// squared-distance search over the first PALETTE_SIZE entries, strict less-than
	function automatic logic [IDX_W-1:0] nearest_entry(input logic [CHAN_W-1:0] r,
			input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
		int                  span;
		int                  best;
		int                  best_d;
		int                  d;
		int                  dr;
		int                  dg;
		int                  db;
		logic [3*CHAN_W-1:0] c;
		span = (PALETTE_SIZE > ROM_ENTRIES) ? ROM_ENTRIES :
			((PALETTE_SIZE < 1) ? 1 : PALETTE_SIZE);
		best = 0;
		best_d = 32'h7fff_ffff;
		for (int k = 0; k < span; k++) begin
			c = PALETTE_ROM[k];
			dr = int'(r) - int'(c[3*CHAN_W-1:2*CHAN_W]);
			dg = int'(g) - int'(c[2*CHAN_W-1:CHAN_W]);
			db = int'(b) - int'(c[CHAN_W-1:0]);
			d = dr * dr + dg * dg + db * db;
			if (d < best_d) begin
				best_d = d;
				best = k;
			end
		end
		return IDX_W'(best + 1);
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $realtime, what);
		mismatches++;
	endtask

	always @(posedge clk) begin
		logic [IDX_W-1:0] want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				matched++;
				if (expected_index_q.size() == 0) begin
					report_mismatch($sformatf("nearest_idx %0d with no pixel outstanding",
						nearest_idx));
				end else begin
					want = expected_index_q.pop_front();
					if (nearest_idx !== want)
						report_mismatch($sformatf("nearest_idx %0d, expected %0d",
							nearest_idx, want));
				end
				if (nearest_idx >= 1 && nearest_idx <= ROM_ENTRIES &&
						!index_seen[nearest_idx]) begin
					index_seen[nearest_idx] = 1'b1;
					indices_hit++;
				end
			end
			if (in_valid && !in_stall)
				expected_index_q.push_back(nearest_entry(red, green, blue));
			if (in_valid && in_stall)
				input_backpressure++;
			awaited = expected_index_q.size();
		end
	end

endmodule

[dv/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import npc_pkg::*;

	localparam int PALETTE_SIZE = PALETTE_SIZE_DEF;
	// register depth of the palette row, used for the final drain wait
	localparam int LATENCY      = 2 * PALETTE_SIZE;
	// long output hold-off: well beyond the row depth so the input must stall
	localparam int HOLD_CYCLES  = 400;
	// ~900 pixels plus hold-off and drains, with a wide margin
	localparam int CYCLE_LIMIT  = 200000;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	logic [CHAN_W-1:0] red       = '0;
	logic [CHAN_W-1:0] green     = '0;
	logic [CHAN_W-1:0] blue      = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [IDX_W-1:0]  nearest_idx;

	int mismatches;
	int awaited;
	int matched;
	int indices_hit;
	int input_backpressure;

	// idle ranges per phase; zero gives stretches with no idling
	int snd_max_gap = 0;
	int rcv_max_gap = 0;
	// raised by stimulus to make the receiver hold off for HOLD_CYCLES
	bit hold_req    = 1'b0;
	int pixels_sent = 0;
	int cycles      = 0;

	always #1 clk = ~clk;

	nearest_palette_color #(
		.PALETTE_SIZE (PALETTE_SIZE)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.nearest_idx   (nearest_idx)
	);

	nearest_palette_color_checker #(
		.PALETTE_SIZE (PALETTE_SIZE)
	) checker_i (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.red                (red),
		.green              (green),
		.blue               (blue),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.nearest_idx        (nearest_idx),
		.mismatches         (mismatches),
		.awaited            (awaited),
		.matched            (matched),
		.indices_hit        (indices_hit),
		.input_backpressure (input_backpressure)
	);

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, awaited);
			$display("nearest_palette_color verification failed");
			$finish;
		end
	end

	// One pixel transaction. Idle cycles first (valid low), then present the pixel at a
	// falling edge and hold it until a rising edge sees in_stall low. With no idle cycles
	// valid stays high straight into the next pixel, so it gets one assignment per edge.
	task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
			input logic [CHAN_W-1:0] b);
		int gap;
		gap = $urandom_range(snd_max_gap);
		repeat (gap) @(negedge clk) in_valid <= 1'b0;
		@(negedge clk);
		in_valid <= 1'b1;
		red      <= r;
		green    <= g;
		blue     <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pixels_sent++;
	endtask

	// sender pause: drop valid and wait until every predicted index has come back
	task automatic rest_and_drain();
		@(negedge clk) in_valid <= 1'b0;
		while (awaited != 0) @(negedge clk);
	endtask

	// nudge a channel by up to +/-8, saturating at the 8-bit range
	function automatic logic [CHAN_W-1:0] jitter(input logic [CHAN_W-1:0] v);
		int t;
		t = int'(v) + int'($urandom_range(16)) - 8;
		if (t < 0)
			t = 0;
		if (t > 255)
			t = 255;
		return CHAN_W'(t);
	endfunction

	// Random pixel mix. Uniform pixels toggle every bit; pixels near a palette color
	// steer the search to a randomly chosen index; exact colors hit zero distance (and the
	// duplicated last pair); midpoints of two colors go after equal-distance ties.
	task automatic pick_pixel(output logic [CHAN_W-1:0] r, output logic [CHAN_W-1:0] g,
			output logic [CHAN_W-1:0] b);
		int                  kind;
		int                  ia;
		int                  ib;
		logic [3*CHAN_W-1:0] pa;
		logic [3*CHAN_W-1:0] pb;
		kind = $urandom_range(99);
		ia = $urandom_range(ROM_ENTRIES - 1);
		ib = $urandom_range(ROM_ENTRIES - 1);
		pa = PALETTE_ROM[ia];
		pb = PALETTE_ROM[ib];
		if (kind < 35) begin
			{r, g, b} = (3 * CHAN_W)'($urandom);
		end else if (kind < 70) begin
			r = jitter(pa[3*CHAN_W-1:2*CHAN_W]);
			g = jitter(pa[2*CHAN_W-1:CHAN_W]);
			b = jitter(pa[CHAN_W-1:0]);
		end else if (kind < 80) begin
			{r, g, b} = pa;
		end else begin
			r = CHAN_W'((int'(pa[3*CHAN_W-1:2*CHAN_W]) + int'(pb[3*CHAN_W-1:2*CHAN_W])) / 2);
			g = CHAN_W'((int'(pa[2*CHAN_W-1:CHAN_W]) + int'(pb[2*CHAN_W-1:CHAN_W])) / 2);
			b = CHAN_W'((int'(pa[CHAN_W-1:0]) + int'(pb[CHAN_W-1:0])) / 2);
		end
	endtask

	// Result side. Each result waits a random number of stalled cycles, or the long
	// hold-off when asked, then takes the next result at the first edge with stall low.
	initial begin
		int wait_n;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk) out_stall <= 1'b1;
			end else begin
				wait_n = $urandom_range(rcv_max_gap);
				repeat (wait_n) @(negedge clk) out_stall <= 1'b1;
			end
			@(negedge clk) out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// Stimulus and verdict
	initial begin
		logic [3*CHAN_W-1:0] corner_px [19] = '{
			24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
			24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
			// exact palette colors: first, second, pure red entry, grey
			24'h1A0A94, 24'h0F75FF, 24'hEC0000, 24'h808080,
			// duplicated last pair: the lower of the two must win
			24'hFFC8C8, 24'hFEC9C7,
			// halfway between the two greys: equal distance, lower index wins
			24'h717171,
			24'h010101, 24'hAAAAAA, 24'h55AA55, 24'h7F7F7F
		};
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed corners, light idling on both sides
		snd_max_gap = 3;
		rcv_max_gap = 3;
		foreach (corner_px[i])
			send_pixel(corner_px[i][3*CHAN_W-1:2*CHAN_W], corner_px[i][2*CHAN_W-1:CHAN_W],
				corner_px[i][CHAN_W-1:0]);
		rest_and_drain();

		// random traffic with full idle range on both sides
		snd_max_gap = 10;
		rcv_max_gap = 10;
		repeat (300) begin
			pick_pixel(r, g, b);
			send_pixel(r, g, b);
		end

		// back-to-back stretch, no idling anywhere
		snd_max_gap = 0;
		rcv_max_gap = 0;
		repeat (150) begin
			pick_pixel(r, g, b);
			send_pixel(r, g, b);
		end

		// receiver holds off while pixels keep coming: the row fills and stalls the input
		hold_req = 1'b1;
		rcv_max_gap = 10;
		repeat (200) begin
			pick_pixel(r, g, b);
			send_pixel(r, g, b);
		end
		rest_and_drain();

		snd_max_gap = 10;
		repeat (200) begin
			pick_pixel(r, g, b);
			send_pixel(r, g, b);
		end
		rest_and_drain();

		// let any stray result surface before the verdict
		repeat (LATENCY + 20) @(posedge clk);

		$display("Sent %0d pixels, checked %0d indices; %0d distinct palette indices returned",
			pixels_sent, matched, indices_hit);
		$display("Input stalled %0d cycles by output back-pressure; %0d mismatches",
			input_backpressure, mismatches);
		if (mismatches == 0) begin
			$display("nearest_palette_color verification clean");
		end else begin
			$display("nearest_palette_color verification failed");
		end
		$finish;
	end

endmodule
